// ----- hw/rtl/local_abs_difference_binarizer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for local_abs_difference_binarizer
// Clocked checks, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef LOCAL_ABS_DIFFERENCE_BINARIZER_ASSERT_SVH
`define LOCAL_ABS_DIFFERENCE_BINARIZER_ASSERT_SVH

// checked only out of reset
`define LADB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked in reset too
`define LADB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ladb_pkg.sv -----
// ----------------------------------------------------------------------------
// ladb_pkg
// Shared constants, types and control structs of the edge binarizer.
// ----------------------------------------------------------------------------
package ladb_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int MAX_RADIUS  = 8;
	localparam int STORE_DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CFG_W       = 12;
	localparam int POS_W       = 11;
	localparam int RAD_W       = 4;
	localparam int OFS_W       = RAD_W + 1;
	localparam int PIX_W       = 8;
	localparam int CNT_W       = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
	localparam int SUM_W       = CNT_W + PIX_W;

	typedef enum logic [1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_RADIUS    = 2'd2,
		REG_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CENTRE,
		ST_LOAD,
		ST_SWEEP,
		ST_TAIL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take_item;
		logic start;
		logic base;
		logic load_centre;
		logic sweep;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic emit_ok;
		logic sweep_last;
		logic out_free;
	} ctl_sts_t;

endpackage

// ----- hw/rtl/ladb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ladb_ctrl
// Sequencer: takes one beat, checks readiness and, if ready, sweeps the disc and emits.
// ----------------------------------------------------------------------------
module ladb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ladb_pkg::ctl_sts_t sts,
	output ladb_pkg::ctl_cmd_t cmd
);

	ladb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ladb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ladb_pkg::ST_IDLE: begin
				if (in_valid) state_d = ladb_pkg::ST_CHECK;
			end
			ladb_pkg::ST_CHECK: begin
				state_d = sts.emit_ok ? ladb_pkg::ST_CENTRE : ladb_pkg::ST_IDLE;
			end
			ladb_pkg::ST_CENTRE: state_d = ladb_pkg::ST_LOAD;
			ladb_pkg::ST_LOAD:   state_d = ladb_pkg::ST_SWEEP;
			ladb_pkg::ST_SWEEP: begin
				if (sts.sweep_last) state_d = ladb_pkg::ST_TAIL;
			end
			ladb_pkg::ST_TAIL:   state_d = ladb_pkg::ST_DONE;
			ladb_pkg::ST_DONE: begin
				if (sts.out_free) state_d = ladb_pkg::ST_IDLE;
			end
			default: state_d = ladb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ladb_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.take_item = in_valid;
			end
			ladb_pkg::ST_CHECK:  cmd.start       = 1'b1;
			ladb_pkg::ST_CENTRE: cmd.base        = 1'b1;
			ladb_pkg::ST_LOAD:   cmd.load_centre = 1'b1;
			ladb_pkg::ST_SWEEP:  cmd.sweep       = 1'b1;
			ladb_pkg::ST_TAIL: begin
			end
			ladb_pkg::ST_DONE:   cmd.finish      = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/ladb_datapath.sv -----
// ----------------------------------------------------------------------------
// ladb_datapath
// Config registers, line store, raster counters, disc accumulator, result reg.
// ----------------------------------------------------------------------------
module ladb_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ladb_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          req_type,
	input  logic [ladb_pkg::PIX_W-1:0]    pixel_value,
	input  ladb_pkg::ctl_cmd_t            cmd,
	output ladb_pkg::ctl_sts_t            sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          edge_flag,
	output logic [ladb_pkg::POS_W-1:0]    out_row,
	output logic [ladb_pkg::POS_W-1:0]    out_col,
	output logic                          frame_last
);

	localparam int AW  = ladb_pkg::ADDR_W;
	localparam int CW  = ladb_pkg::CFG_W;
	localparam int PW  = ladb_pkg::POS_W;
	localparam int OW  = ladb_pkg::OFS_W;
	localparam int SAW = AW + 2;
	localparam int SPW = PW + 2;

	logic [CW-1:0]             width_q, height_q;
	logic [ladb_pkg::RAD_W-1:0] radius_q;
	logic [ladb_pkg::PIX_W-1:0] thresh_q;

	logic [PW-1:0] in_row_q, in_col_q, res_row_q, res_col_q;
	logic [AW-1:0] in_addr_q, res_addr_q;
	logic          in_done_q;

	logic [ladb_pkg::PIX_W-1:0] mem [ladb_pkg::STORE_DEPTH];
	logic [ladb_pkg::PIX_W-1:0] rdata_q, centre_q;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;

	logic signed [OW-1:0] dr_q, dc_q;
	logic [AW-1:0]        rw_q, row_q;
	logic                 vld_s1;
	logic [ladb_pkg::SUM_W-1:0] sum_q;
	logic [ladb_pkg::CNT_W-1:0] cnt_q;

	logic                 out_valid_q, edge_q, last_q;
	logic [PW-1:0]        out_row_q, out_col_q;

	logic [CW-1:0]             eff_w, eff_h;
	logic [ladb_pkg::RAD_W-1:0] eff_r;
	logic signed [OW-1:0]      rad_s;
	logic                      restart, pix;
	logic [CW-1:0]             need_r, need_c;
	logic                      emit_ok;
	logic signed [SPW-1:0]     nr, nc;
	logic signed [2*OW-1:0]    dist2, rad2;
	logic                      nb_ok, last_pos;
	logic signed [SAW-1:0]     nb_sum, base_diff, row_sum;
	logic [AW-1:0]             nb_addr, base_addr, row_next;
	logic [ladb_pkg::PIX_W-1:0] absd;
	logic [ladb_pkg::SUM_W-1:0] thr_prod;
	logic [CW-1:0]             in_col_n, in_row_n, res_col_n, res_row_n;
	logic [AW-1:0]             in_addr_n, res_addr_n;

	always_comb begin
		if (width_q == '0) eff_w = CW'(1);
		else if (width_q > CW'(ladb_pkg::MAX_WIDTH)) eff_w = CW'(ladb_pkg::MAX_WIDTH);
		else eff_w = width_q;
		if (height_q == '0) eff_h = CW'(1);
		else if (height_q > CW'(ladb_pkg::MAX_HEIGHT)) eff_h = CW'(ladb_pkg::MAX_HEIGHT);
		else eff_h = height_q;
		eff_r = (radius_q > ladb_pkg::RAD_W'(ladb_pkg::MAX_RADIUS)) ?
			ladb_pkg::RAD_W'(ladb_pkg::MAX_RADIUS) : radius_q;
	end
	assign rad_s = signed'({1'b0, eff_r});

	assign pix     = cmd.take_item && (req_type == ladb_pkg::REQ_PIXEL);
	assign restart = cfg_we && (cfg_index != ladb_pkg::REG_THRESHOLD);
	assign wr_en   = pix;

	// next write position, with a pending frame dropped first
	always_comb begin
		logic [PW-1:0] r0, c0;
		logic [AW-1:0] a0;
		r0 = in_done_q ? '0 : in_row_q;
		c0 = in_done_q ? '0 : in_col_q;
		a0 = in_done_q ? '0 : in_addr_q;
		in_col_n  = {1'b0, c0} + CW'(1);
		in_row_n  = {1'b0, r0} + CW'(1);
		in_addr_n = (a0 == AW'(ladb_pkg::STORE_DEPTH - 1)) ? '0 : a0 + AW'(1);
		res_col_n = {1'b0, res_col_q} + CW'(1);
		res_row_n = {1'b0, res_row_q} + CW'(1);
		res_addr_n = (res_addr_q == AW'(ladb_pkg::STORE_DEPTH - 1)) ? '0 :
			res_addr_q + AW'(1);
	end

	// emit readiness
	always_comb begin
		need_r = {1'b0, res_row_q} + CW'(eff_r);
		if (need_r > eff_h - CW'(1)) need_r = eff_h - CW'(1);
		need_c = {1'b0, res_col_q} + CW'(eff_r);
		if (need_c > eff_w - CW'(1)) need_c = eff_w - CW'(1);
		emit_ok = in_done_q || (need_r < {1'b0, in_row_q}) ||
			((need_r == {1'b0, in_row_q}) && (need_c < {1'b0, in_col_q}));
	end
	assign sts.emit_ok = emit_ok;

	// neighbor address and validity
	always_comb begin
		nr    = signed'({2'b0, res_row_q}) + SPW'(dr_q);
		nc    = signed'({2'b0, res_col_q}) + SPW'(dc_q);
		dist2 = dr_q * dr_q + dc_q * dc_q;
		rad2  = rad_s * rad_s;
		nb_ok = (dist2 <= rad2) && (nr >= 0) && (nc >= 0) &&
			(nr < signed'(SPW'(eff_h))) && (nc < signed'(SPW'(eff_w)));
		last_pos = (dr_q == rad_s) && (dc_q == rad_s);

		nb_sum = signed'(SAW'(row_q)) + SAW'(dc_q);
		if (nb_sum < 0) nb_sum = nb_sum + SAW'(ladb_pkg::STORE_DEPTH);
		else if (nb_sum >= SAW'(ladb_pkg::STORE_DEPTH))
			nb_sum = nb_sum - SAW'(ladb_pkg::STORE_DEPTH);
		nb_addr = nb_sum[AW-1:0];

		base_diff = signed'(SAW'(res_addr_q)) - signed'(SAW'(rw_q));
		if (base_diff < 0) base_diff = base_diff + SAW'(ladb_pkg::STORE_DEPTH);
		base_addr = base_diff[AW-1:0];

		row_sum = signed'(SAW'(row_q)) + signed'(SAW'(eff_w));
		if (row_sum >= SAW'(ladb_pkg::STORE_DEPTH))
			row_sum = row_sum - SAW'(ladb_pkg::STORE_DEPTH);
		row_next = row_sum[AW-1:0];
	end
	assign sts.sweep_last = last_pos;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign rd_addr  = cmd.base ? res_addr_q : nb_addr;
	assign absd     = (rdata_q > centre_q) ? rdata_q - centre_q : centre_q - rdata_q;
	assign thr_prod = ladb_pkg::SUM_W'(thresh_q * cnt_q);

	always_ff @(posedge clk) begin
		if (wr_en) mem[in_done_q ? AW'(0) : in_addr_q] <= pixel_value;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) rw_q <= AW'(eff_r * eff_w);
		if (cmd.load_centre) centre_q <= rdata_q;
		if (cmd.base) row_q <= base_addr;
		else if (cmd.sweep && dc_q == rad_s) row_q <= row_next;
		if (cmd.start) begin
			dr_q <= -rad_s;
			dc_q <= -rad_s;
		end else if (cmd.sweep) begin
			if (dc_q == rad_s) begin
				dc_q <= -rad_s;
				dr_q <= dr_q + OW'(1);
			end else begin
				dc_q <= dc_q + OW'(1);
			end
		end
		if (cmd.start) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (vld_s1) begin
			sum_q <= sum_q + ladb_pkg::SUM_W'(absd);
			cnt_q <= cnt_q + ladb_pkg::CNT_W'(1);
		end
		if (cmd.finish) begin
			edge_q    <= sum_q >= thr_prod;
			out_row_q <= res_row_q;
			out_col_q <= res_col_q;
			last_q    <= (res_col_n >= eff_w) && (res_row_n >= eff_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CW'(640);
			height_q    <= CW'(480);
			radius_q    <= ladb_pkg::RAD_W'(6);
			thresh_q    <= ladb_pkg::PIX_W'(20);
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_addr_q   <= '0;
			res_row_q   <= '0;
			res_col_q   <= '0;
			res_addr_q  <= '0;
			in_done_q   <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.sweep && nb_ok;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					ladb_pkg::REG_WIDTH:     width_q  <= cfg_data;
					ladb_pkg::REG_HEIGHT:    height_q <= cfg_data;
					ladb_pkg::REG_RADIUS:    radius_q <= cfg_data[ladb_pkg::RAD_W-1:0];
					ladb_pkg::REG_THRESHOLD: thresh_q <= cfg_data[ladb_pkg::PIX_W-1:0];
					default: begin
					end
				endcase
			end
			if (restart) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_addr_q  <= '0;
				res_row_q  <= '0;
				res_col_q  <= '0;
				res_addr_q <= '0;
				in_done_q  <= 1'b0;
			end else begin
				if (pix) begin
					if (in_done_q) begin
						res_row_q  <= '0;
						res_col_q  <= '0;
						res_addr_q <= '0;
					end
					in_done_q <= 1'b0;
					if (in_col_n >= eff_w) begin
						in_col_q <= '0;
						if (in_row_n >= eff_h) begin
							in_row_q  <= '0;
							in_addr_q <= '0;
							in_done_q <= 1'b1;
						end else begin
							in_row_q  <= in_row_n[PW-1:0];
							in_addr_q <= in_addr_n;
						end
					end else begin
						in_col_q  <= in_col_n[PW-1:0];
						in_row_q  <= in_done_q ? '0 : in_row_q;
						in_addr_q <= in_addr_n;
					end
				end
				if (cmd.finish) begin
					res_addr_q <= res_addr_n;
					if (res_col_n >= eff_w) begin
						res_col_q <= '0;
						if (res_row_n >= eff_h) begin
							res_row_q  <= '0;
							res_addr_q <= '0;
							in_done_q  <= 1'b0;
						end else begin
							res_row_q <= res_row_n[PW-1:0];
						end
					end else begin
						res_col_q <= res_col_n[PW-1:0];
					end
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_flag  = edge_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = last_q;

endmodule

// ----- hw/rtl/local_abs_difference_binarizer.sv -----
// ----------------------------------------------------------------------------
// local_abs_difference_binarizer
// Disc mean-absolute-difference edge marker over a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  input   | in_valid/in_ready   | req_type, pixel_value
//  output  | out_valid/out_ready | edge_flag, out_row, out_col, frame_last
//  config  | cfg_we              | cfg_index, cfg_data
//
//  A beat with no result ends after the readiness check; one with a result
//  also sweeps the disc of clamped radius R, the single read port
//  of the line store visiting each disc position once.
//  The result register holds one result; a new result waits while it is full.
//  Reset is asynchronous; the line store is not cleared.
// ----------------------------------------------------------------------------
module local_abs_difference_binarizer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [ladb_pkg::PIX_W-1:0] pixel_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       edge_flag,
	output logic [ladb_pkg::POS_W-1:0] out_row,
	output logic [ladb_pkg::POS_W-1:0] out_col,
	output logic                       frame_last,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [ladb_pkg::CFG_W-1:0] cfg_data
);

	ladb_pkg::ctl_cmd_t cmd;
	ladb_pkg::ctl_sts_t sts;

	ladb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ladb_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.pixel_value (pixel_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.edge_flag   (edge_flag),
		.out_row     (out_row),
		.out_col     (out_col),
		.frame_last  (frame_last)
	);

endmodule

// ----- hw/rtl/ladb_checker.sv -----
// ----------------------------------------------------------------------------
// ladb_checker
// Port-level checks for local_abs_difference_binarizer.
// ----------------------------------------------------------------------------
`include "local_abs_difference_binarizer_assert.svh"

module ladb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       edge_flag,
	input logic [ladb_pkg::POS_W-1:0] out_row,
	input logic [ladb_pkg::POS_W-1:0] out_col,
	input logic                       frame_last
);

	`LADB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(edge_flag) &&
		$stable(out_row) && $stable(out_col) && $stable(frame_last),
		"result changed while stalled")
	`LADB_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "beat taken while busy")
	`LADB_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid, "result valid in reset")

endmodule

bind local_abs_difference_binarizer ladb_checker u_ladb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.edge_flag  (edge_flag),
	.out_row    (out_row),
	.out_col    (out_col),
	.frame_last (frame_last)
);
